FILE: sv/cdfis_pkg.sv
// ----------------------------------------------------------------------------
// cdfis_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package cdfis_pkg;

	localparam int MAX_BINS   = 1024;
	localparam int VALUE_BITS = 24;
	localparam int IDX_W      = 11;
	localparam int BIN_W      = 10;
	localparam int FRAC_W     = 16;
	localparam int DENS_W     = 34;
	localparam int OP_W       = 2;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 112;
	localparam int DIV_CNT_W  = 4;

	// input operation codes
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_CONT  = 2'd1;
	localparam logic [OP_W-1:0] OP_DISC  = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

	// table read address selects
	localparam logic [1:0] RD_TOTAL = 2'd0;
	localparam logic [1:0] RD_PROBE = 2'd1;
	localparam logic [1:0] RD_LO    = 2'd2;
	localparam logic [1:0] RD_HI    = 2'd3;

	typedef struct packed {
		logic       capture;
		logic       mem_we;
		logic       search_init;
		logic       search_step;
		logic       bin_from_search;
		logic       bin_from_index;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       total_chk;
		logic       lo_cap;
		logic       hi_cap;
		logic       wid_calc;
		logic       mul_div_init;
		logic       div_step;
		logic       out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic            count_zero;
		logic            total_zero;
		logic            div_last;
		logic [OP_W-1:0] op;
	} dp_status_t;

endpackage

FILE: sv/cdfis_ctrl.sv
// ----------------------------------------------------------------------------
// cdfis_ctrl
// sequencer for load, search, width lookup, multiply and divide steps
// ----------------------------------------------------------------------------
module cdfis_ctrl import cdfis_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [OP_W-1:0] in_op,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  dp_status_t      status,
	output ctrl_cmd_t       cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_TOT_RD  = 4'd1;
	localparam logic [3:0] S_TOT_CHK = 4'd2;
	localparam logic [3:0] S_PROBE   = 4'd3;
	localparam logic [3:0] S_CMP     = 4'd4;
	localparam logic [3:0] S_LO_RD   = 4'd5;
	localparam logic [3:0] S_HI_RD   = 4'd6;
	localparam logic [3:0] S_HI_CAP  = 4'd7;
	localparam logic [3:0] S_WID     = 4'd8;
	localparam logic [3:0] S_MUL     = 4'd9;
	localparam logic [3:0] S_DIV     = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture     = 1'b1;
					cmd.search_init = 1'b1;
					case (in_op)
						OP_LOAD: begin
							cmd.mem_we = 1'b1;
							state_d    = S_DONE;
						end
						OP_CONT: state_d = S_PROBE;
						OP_DISC: state_d = S_TOT_RD;
						default: begin
							cmd.bin_from_index = 1'b1;
							state_d            = S_LO_RD;
						end
					endcase
				end
			end
			S_TOT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_TOTAL;
				state_d    = S_TOT_CHK;
			end
			S_TOT_CHK: begin
				cmd.total_chk = 1'b1;
				state_d       = status.total_zero ? S_DONE : S_PROBE;
			end
			S_PROBE: begin
				if (status.count_zero) begin
					cmd.bin_from_search = 1'b1;
					state_d             = S_LO_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PROBE;
					state_d    = S_CMP;
				end
			end
			S_CMP: begin
				cmd.search_step = 1'b1;
				state_d         = S_PROBE;
			end
			S_LO_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_LO;
				state_d    = S_HI_RD;
			end
			S_HI_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_HI;
				cmd.lo_cap = 1'b1;
				state_d    = S_HI_CAP;
			end
			S_HI_CAP: begin
				cmd.hi_cap = 1'b1;
				state_d    = S_WID;
			end
			S_WID: begin
				cmd.wid_calc = 1'b1;
				state_d      = S_MUL;
			end
			S_MUL: begin
				cmd.mul_div_init = 1'b1;
				state_d          = (status.op == OP_CONT) ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_PROBE)
		else $error("compare step without a preceding probe read");

	a_load_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_op == OP_LOAD |=> state_q == S_DONE)
		else $error("load transaction did not go straight to result");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && !status.div_last |=> state_q == S_DIV)
		else $error("divider left before its last step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || m_tready)
		else $error("result register overwritten before it was taken");
`endif

endmodule

FILE: sv/cdfis_dp.sv
// ----------------------------------------------------------------------------
// cdfis_dp
// table memory, search registers, width, multiplier and restoring divider
// ----------------------------------------------------------------------------
module cdfis_dp import cdfis_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [OP_W-1:0]       in_op,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_W-1:0]      cfg_data,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [0:0]            out_user,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status
);

	localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_BINS);

	logic [VALUE_BITS-1:0] mem [0:MAX_BINS];
	logic [VALUE_BITS-1:0] rd_q;
	logic [IDX_W-1:0]      rd_addr;

	logic [IDX_W-1:0]      cfg_q;
	logic [IDX_W-1:0]      n_eff;
	logic [IDX_W-1:0]      n_m1;

	logic [IDX_W-1:0]      in_idx;
	logic [VALUE_BITS-1:0] in_val;
	logic [VALUE_BITS-1:0] in_smp;

	logic [OP_W-1:0]       op_q;
	logic [VALUE_BITS-1:0] sample_q;
	logic                  tz_q;
	logic [IDX_W-1:0]      first_q;
	logic [IDX_W-1:0]      count_q;
	logic [IDX_W-1:0]      half;
	logic [BIN_W-1:0]      bin_q;
	logic [VALUE_BITS-1:0] lo_q;
	logic [VALUE_BITS-1:0] hi_q;
	logic [VALUE_BITS-1:0] w_q;
	logic [DENS_W-1:0]     dens_q;
	logic [DENS_W:0]       prod;

	logic [VALUE_BITS-1:0] rem_q;
	logic [FRAC_W-1:0]     quot_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  frac_zero_q;
	logic                  frac_sat_q;
	logic [VALUE_BITS:0]   rem2;
	logic [VALUE_BITS:0]   rem_sub;
	logic [VALUE_BITS-1:0] diff;
	logic [FRAC_W-1:0]     frac;

	logic [BIN_W-1:0]      o_bin;
	logic [FRAC_W-1:0]     o_frac;
	logic [VALUE_BITS-1:0] o_width;
	logic [DENS_W-1:0]     o_dens;
	logic [VALUE_BITS-1:0] o_cval;
	logic                  o_zw;

	assign in_idx = in_data[IDX_W-1:0];
	assign in_val = in_data[IDX_W +: VALUE_BITS];
	assign in_smp = in_data[IDX_W+VALUE_BITS +: VALUE_BITS];

	// effective bin count, saturated into 1..max
	assign cfg_ready = 1'b1;
	assign n_eff = (cfg_q == '0) ? IDX_W'(1) : ((cfg_q > MAX_N) ? MAX_N : cfg_q);
	assign n_m1  = n_eff - IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= MAX_N;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_TOTAL: rd_addr = n_eff;
			RD_PROBE: rd_addr = first_q + half;
			RD_LO:    rd_addr = {1'b0, bin_q};
			default:  rd_addr = {1'b0, bin_q} + IDX_W'(1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we && in_idx <= MAX_N) begin
			mem[in_idx] <= in_val;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign half = {1'b0, count_q[IDX_W-1:1]};

	// search, operand capture and width
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_op;
			sample_q <= in_smp;
			tz_q     <= 1'b0;
		end
		if (cmd.search_init) begin
			first_q <= '0;
			count_q <= n_eff;
		end
		if (cmd.search_step) begin
			if (sample_q >= rd_q) begin
				first_q <= first_q + half + IDX_W'(1);
				count_q <= count_q - half - IDX_W'(1);
			end else begin
				count_q <= half;
			end
		end
		if (cmd.total_chk) begin
			tz_q <= (rd_q == '0);
		end
		if (cmd.bin_from_index) begin
			bin_q <= (in_idx > n_m1) ? n_m1[BIN_W-1:0] : in_idx[BIN_W-1:0];
		end
		if (cmd.bin_from_search) begin
			bin_q <= (first_q == '0) ? '0 : BIN_W'(first_q - IDX_W'(1));
		end
		if (cmd.lo_cap) begin
			lo_q <= rd_q;
		end
		if (cmd.hi_cap) begin
			hi_q <= rd_q;
		end
		if (cmd.wid_calc) begin
			w_q <= (hi_q >= lo_q) ? (hi_q - lo_q) : '0;
		end
	end

	assign prod    = (DENS_W+1)'(w_q) * (DENS_W+1)'(n_eff);
	assign diff    = sample_q - lo_q;
	assign rem2    = {rem_q, 1'b0};
	assign rem_sub = rem2 - {1'b0, w_q};

	// density product and 16-step restoring divide of (s - lo) << 16 by width
	always_ff @(posedge clk) begin
		if (cmd.mul_div_init) begin
			dens_q      <= prod[DENS_W-1:0];
			rem_q       <= diff;
			quot_q      <= '0;
			div_cnt_q   <= '0;
			frac_zero_q <= (w_q == '0) || (sample_q <= lo_q);
			frac_sat_q  <= (diff >= w_q);
		end
		if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (rem2 >= {1'b0, w_q}) begin
				rem_q  <= rem_sub[VALUE_BITS-1:0];
				quot_q <= {quot_q[FRAC_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem2[VALUE_BITS-1:0];
				quot_q <= {quot_q[FRAC_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (frac_zero_q) begin
			frac = '0;
		end else if (frac_sat_q) begin
			frac = '1;
		end else begin
			frac = quot_q;
		end
	end

	always_comb begin
		o_bin   = bin_q;
		o_frac  = '0;
		o_width = w_q;
		o_dens  = dens_q;
		o_cval  = lo_q;
		o_zw    = (w_q == '0);
		case (op_q)
			OP_LOAD: begin
				o_bin   = '0;
				o_width = '0;
				o_dens  = '0;
				o_cval  = '0;
				o_zw    = 1'b0;
			end
			OP_CONT: o_frac = frac;
			OP_DISC: begin
				o_dens = '0;
				if (tz_q) begin
					o_bin   = '0;
					o_width = '0;
					o_cval  = '0;
					o_zw    = 1'b1;
				end
			end
			default: o_frac = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data <= {4'b0, o_cval, o_dens, o_width, o_frac, o_bin};
			out_user <= o_zw;
		end
	end

	assign status.count_zero = (count_q == '0);
	assign status.total_zero = (rd_q == '0);
	assign status.div_last   = (div_cnt_q == '1);
	assign status.op         = op_q;

endmodule

FILE: sv/cdf_table_inverse_sampler_unit.sv
// ----------------------------------------------------------------------------
// cdf_table_inverse_sampler_unit
// ops: 0 load, 1 continuous sample, 2 discrete sample, 3 query by index
// a search takes floor(log2(n + 1)) to floor(log2(n)) + 1 probes (10 or 11 at n = 1024)
// one transaction at a time: each probe is a registered read of the single table port,
// and the continuous fraction comes from a restoring divider
// asynchronous active-low reset clears the sequencer, output valid and bins_in_use (1024);
// the table itself is not cleared and must be loaded before use
// ----------------------------------------------------------------------------
module cdf_table_inverse_sampler_unit import cdfis_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_index[10:0], entry_value[34:11], sample[58:35]
	input  logic [OP_W-1:0]       s_tuser,   // op[1:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // bin[9:0], fraction[25:10], bin_width[49:26],
	                                         // density[83:50], cdf_value[107:84]
	output logic [0:0]            m_tuser,   // zero_width[0]
	// bins_in_use write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_W-1:0]      cfg_data
);

	// command and status between sequencer and datapath
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer: owns input ready, result valid and the step order
	cdfis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_op    (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: table memory, search, width, density and fraction
	cdfis_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_tuser),
		.in_data   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
